// ===== rtl/tlbl_pkg.sv =====
// tlbl_pkg: shared types, constants and helpers for the lca lifting block
// no dependencies
package tlbl_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 11;
  localparam int NODE_W      = 11;
  localparam int LVL_W       = 4;
  localparam int DEPTH_W     = 10;
  localparam int TBL_AW      = LVL_W + NODE_W;
  localparam int TBL_DEPTH   = LIFT_LEVELS << NODE_W;
  localparam int DEP_DEPTH   = MAX_NODES + 1;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [NODE_W-1:0]  LAST_NODE = NODE_W'(MAX_NODES);
  localparam logic [LVL_W-1:0]   TOP_LVL   = LVL_W'(LIFT_LEVELS - 1);
  localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_NODES - 1);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_BUILD,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              ok;
    logic [NODE_W-1:0] x;
    logic [NODE_W-1:0] y;
  } qent_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_B0_RD,
    ST_B0_WR,
    ST_BK_RD1,
    ST_BK_RD2,
    ST_BK_WR,
    ST_BD_RD,
    ST_BD_WT,
    ST_Q_DA,
    ST_Q_DB,
    ST_Q_DW,
    ST_Q_UP,
    ST_Q_UP_WT,
    ST_Q_EQ,
    ST_Q_JU,
    ST_Q_JV,
    ST_Q_JC,
    ST_Q_FIN,
    ST_Q_FWT,
    ST_RESP
  } state_t;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [NODE_W-1:0] node);
    tbl_addr = {lvl, node};
  endfunction

endpackage

// ===== rtl/tlbl_ram.sv =====
// tlbl_ram: generic single write, single read ram with registered read
// no dependencies
module tlbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tlbl_front.sv =====
// tlbl_front: request intake, node count register, classification and queue
// depends on tlbl_pkg
module tlbl_front import tlbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] cfg_wr_data,
  output logic [NODE_W-1:0] n_eff,
  output logic              q_valid,
  output qent_t             q_head,
  input  logic              q_pop
);

  logic [NODE_W-1:0] count_cfg_r;
  qent_t             ent_r [2];
  logic              wptr_r, rptr_r;
  logic [1:0]        fill_r;
  qent_t             ent_in;
  logic              push, keep;
  logic [NODE_W-1:0] child, boss, qa, qb;

  assign child = in_tdata[10:0];
  assign boss  = in_tdata[21:11];
  assign qa    = in_tdata[32:22];
  assign qb    = in_tdata[43:33];

  assign n_eff     = (count_cfg_r > LAST_NODE) ? LAST_NODE : count_cfg_r;
  assign in_tready = (fill_r != 2'd2);
  assign q_valid   = (fill_r != 2'd0);
  assign q_head    = ent_r[rptr_r];

  always_comb begin
    ent_in = '{op: OP_LOAD, ok: 1'b0, x: child, y: boss};
    keep   = 1'b1;
    case (in_tuser)
      REQ_LOAD: begin
        ent_in.ok = (child >= NODE_W'(2)) && (child <= LAST_NODE);
      end
      REQ_BUILD: begin
        ent_in.op = OP_BUILD;
      end
      REQ_QUERY: begin
        ent_in.op = OP_QUERY;
        ent_in.x  = qa;
        ent_in.y  = qb;
        ent_in.ok = (qa != '0) && (qa <= n_eff) && (qb != '0) && (qb <= n_eff);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_tvalid && in_tready && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_cfg_r <= NODE_W'(1);
      wptr_r      <= 1'b0;
      rptr_r      <= 1'b0;
      fill_r      <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        count_cfg_r <= cfg_wr_data;
      end
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop) begin
        rptr_r <= ~rptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= ent_in;
    end
  end

endmodule

// ===== rtl/tlbl_back.sv =====
// tlbl_back: executes loads, table build and lifting queries on the memories
// depends on tlbl_pkg and tlbl_ram
module tlbl_back import tlbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] n_eff,
  input  logic              q_valid,
  input  qent_t             q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic [0:0]        out_tuser
);

  state_t             state_r, state_nxt;
  logic [NODE_W-1:0]  i_r, i_nxt, u_r, u_nxt, v_r, v_nxt, au_r, au_nxt;
  logic [LVL_W-1:0]   k_r, k_nxt;
  logic [NODE_W-1:0]  d_r, d_nxt, d_add;
  logic [DEPTH_W-1:0] du_r, du_nxt;
  logic [NODE_W-1:0]  diff_r, diff_nxt;
  logic               built_r, built_nxt;
  logic [NODE_W-1:0]  res_r, res_nxt;
  logic               bad_r, bad_nxt;
  logic               ov_r, ov_nxt;
  logic [NODE_W-1:0]  ores_r, ores_nxt;
  logic               obad_r, obad_nxt;

  logic               t_we, t_re, d_we, d_re;
  logic [TBL_AW-1:0]  t_waddr, t_raddr;
  logic [NODE_W-1:0]  t_wdata, t_rdata, d_waddr, d_raddr;
  logic [DEPTH_W-1:0] d_wdata, d_rdata;
  logic               slot_free, i_last, k_last;

  tlbl_ram #(.WIDTH(NODE_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  tlbl_ram #(.WIDTH(DEPTH_W), .DEPTH(DEP_DEPTH)) u_dep (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );

  assign slot_free  = !ov_r || out_tready;
  assign i_last     = (i_r == LAST_NODE);
  assign k_last     = (k_r == '0);
  assign d_add      = (t_rdata != '0) ? d_r + (NODE_W'(1) << k_r) : d_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, ores_r};
  assign out_tuser  = obad_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && q_head.op == OP_BUILD) begin
          state_nxt = ST_B0_RD;
        end else if (q_valid && q_head.op == OP_QUERY) begin
          state_nxt = (q_head.ok && built_r) ? ST_Q_DA : ST_RESP;
        end
      end
      ST_B0_RD:  state_nxt = ST_B0_WR;
      ST_B0_WR:  state_nxt = i_last ? ST_BK_RD1 : ST_B0_RD;
      ST_BK_RD1: state_nxt = ST_BK_RD2;
      ST_BK_RD2: begin
        if (t_rdata != '0) begin
          state_nxt = ST_BK_WR;
        end else if (i_last && k_r == TOP_LVL) begin
          state_nxt = ST_BD_RD;
        end else begin
          state_nxt = ST_BK_RD1;
        end
      end
      ST_BK_WR:  state_nxt = (i_last && k_r == TOP_LVL) ? ST_BD_RD : ST_BK_RD1;
      ST_BD_RD:  state_nxt = ST_BD_WT;
      ST_BD_WT:  state_nxt = (k_last && i_last) ? ST_IDLE : ST_BD_RD;
      ST_Q_DA:   state_nxt = ST_Q_DB;
      ST_Q_DB:   state_nxt = ST_Q_DW;
      ST_Q_DW:   state_nxt = ST_Q_UP;
      ST_Q_UP: begin
        if (diff_r[k_r]) begin
          state_nxt = ST_Q_UP_WT;
        end else if (k_last) begin
          state_nxt = ST_Q_EQ;
        end
      end
      ST_Q_UP_WT: state_nxt = k_last ? ST_Q_EQ : ST_Q_UP;
      ST_Q_EQ:    state_nxt = (u_r == v_r) ? ST_RESP : ST_Q_JU;
      ST_Q_JU:    state_nxt = ST_Q_JV;
      ST_Q_JV:    state_nxt = ST_Q_JC;
      ST_Q_JC:    state_nxt = k_last ? ST_Q_FIN : ST_Q_JU;
      ST_Q_FIN:   state_nxt = ST_Q_FWT;
      ST_Q_FWT:   state_nxt = ST_RESP;
      ST_RESP:    state_nxt = slot_free ? ST_IDLE : ST_RESP;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    i_nxt = i_r; u_nxt = u_r; v_nxt = v_r; au_nxt = au_r; k_nxt = k_r;
    d_nxt = d_r; du_nxt = du_r; diff_nxt = diff_r; built_nxt = built_r;
    res_nxt = res_r; bad_nxt = bad_r;
    ores_nxt = ores_r; obad_nxt = obad_r;
    ov_nxt = ov_r && !out_tready;
    q_pop = 1'b0;
    t_we = 1'b0; t_waddr = tbl_addr('0, i_r); t_wdata = '0;
    t_re = 1'b0; t_raddr = tbl_addr(k_r, u_r);
    d_we = 1'b0; d_waddr = i_r; d_wdata = '0;
    d_re = 1'b0; d_raddr = u_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_head.op)
            OP_LOAD: begin
              t_we      = q_head.ok;
              t_waddr   = tbl_addr('0, q_head.x);
              t_wdata   = q_head.y;
              built_nxt = 1'b0;
            end
            OP_BUILD: begin
              i_nxt = '0;
            end
            OP_QUERY: begin
              u_nxt   = q_head.x;
              v_nxt   = q_head.y;
              res_nxt = '0;
              bad_nxt = !(q_head.ok && built_r);
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_B0_RD: begin
        t_re    = 1'b1;
        t_raddr = tbl_addr('0, i_r);
      end
      ST_B0_WR: begin
        t_we = 1'b1;
        if (i_r > NODE_W'(1) && i_r <= n_eff && t_rdata != '0 && t_rdata <= n_eff) begin
          t_wdata = t_rdata;
        end
        if (i_last) begin
          i_nxt = '0;
          k_nxt = LVL_W'(1);
        end else begin
          i_nxt = i_r + NODE_W'(1);
        end
      end
      ST_BK_RD1: begin
        t_re    = 1'b1;
        t_raddr = tbl_addr(k_r - LVL_W'(1), i_r);
      end
      ST_BK_RD2, ST_BK_WR: begin
        if (state_r == ST_BK_RD2) begin
          t_re    = 1'b1;
          t_raddr = tbl_addr(k_r - LVL_W'(1), t_rdata);
        end
        if (state_r == ST_BK_WR || t_rdata == '0) begin
          t_we    = 1'b1;
          t_waddr = tbl_addr(k_r, i_r);
          t_wdata = (state_r == ST_BK_WR) ? t_rdata : '0;
          if (i_last) begin
            i_nxt = '0;
            if (k_r == TOP_LVL) begin
              u_nxt = '0;
              d_nxt = '0;
            end else begin
              k_nxt = k_r + LVL_W'(1);
            end
          end else begin
            i_nxt = i_r + NODE_W'(1);
          end
        end
      end
      ST_BD_RD: begin
        t_re = 1'b1;
      end
      ST_BD_WT: begin
        d_nxt = d_add;
        if (t_rdata != '0) begin
          u_nxt = t_rdata;
        end
        if (k_last) begin
          d_we    = 1'b1;
          d_wdata = (d_add > NODE_W'(MAX_DEPTH)) ? MAX_DEPTH : d_add[DEPTH_W-1:0];
          i_nxt   = i_r + NODE_W'(1);
          u_nxt   = i_r + NODE_W'(1);
          d_nxt   = '0;
          k_nxt   = TOP_LVL;
          if (i_last) begin
            built_nxt = 1'b1;
          end
        end else begin
          k_nxt = k_r - LVL_W'(1);
        end
      end
      ST_Q_DA: begin
        d_re = 1'b1;
      end
      ST_Q_DB: begin
        du_nxt  = d_rdata;
        d_re    = 1'b1;
        d_raddr = v_r;
      end
      ST_Q_DW: begin
        k_nxt = TOP_LVL;
        if (du_r < d_rdata) begin
          u_nxt    = v_r;
          v_nxt    = u_r;
          diff_nxt = NODE_W'(d_rdata - du_r);
        end else begin
          diff_nxt = NODE_W'(du_r - d_rdata);
        end
      end
      ST_Q_UP: begin
        t_re = diff_r[k_r];
        if (!diff_r[k_r] && !k_last) begin
          k_nxt = k_r - LVL_W'(1);
        end
      end
      ST_Q_UP_WT: begin
        u_nxt = t_rdata;
        if (!k_last) begin
          k_nxt = k_r - LVL_W'(1);
        end
      end
      ST_Q_EQ: begin
        res_nxt = u_r;
        k_nxt   = TOP_LVL;
      end
      ST_Q_JU: begin
        t_re = 1'b1;
      end
      ST_Q_JV: begin
        au_nxt  = t_rdata;
        t_re    = 1'b1;
        t_raddr = tbl_addr(k_r, v_r);
      end
      ST_Q_JC: begin
        if (au_r != t_rdata) begin
          u_nxt = au_r;
          v_nxt = t_rdata;
        end
        if (!k_last) begin
          k_nxt = k_r - LVL_W'(1);
        end
      end
      ST_Q_FIN: begin
        t_re    = 1'b1;
        t_raddr = tbl_addr('0, u_r);
      end
      ST_Q_FWT: begin
        res_nxt = t_rdata;
      end
      ST_RESP: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ores_nxt = res_r;
          obad_nxt = bad_r;
        end
      end
      default: begin
        ov_nxt = ov_r && !out_tready;
      end
    endcase
    if (cfg_wr_en) begin
      built_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      built_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; u_r <= u_nxt; v_r <= v_nxt; au_r <= au_nxt; k_r <= k_nxt;
    d_r <= d_nxt; du_r <= du_nxt; diff_r <= diff_nxt;
    res_r <= res_nxt; bad_r <= bad_nxt; ores_r <= ores_nxt; obad_r <= obad_nxt;
  end

endmodule

// ===== rtl/tree_lca_binary_lifting.sv =====
// tree_lca_binary_lifting: top level, lowest common ancestor by binary lifting
// depends on tlbl_pkg, tlbl_front, tlbl_back, tlbl_ram
// A load request writes the ancestor memory from the idle state. A build walks the
// ancestor memory one entry at a time over the 1025 nodes: a read and a write for
// level 0, two reads and a write for each higher level (one read and a zero write
// when the ancestor is zero) and a read and a wait per level for the depth pass, set by
// the single read port of the ancestor memory. A query reads both depths, lifts once per
// set bit of the depth difference and, if the nodes still differ, jumps per level.
// Requests queue two deep ahead of the engine; one result waits in the output register.
module tree_lca_binary_lifting import tlbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,    // child_node, boss_node, query_node_a, query_node_b
  input  logic [1:0]        in_tuser,    // req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // common_ancestor
  output logic [0:0]        out_tuser,   // bad_query
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] cfg_wr_data
);

  logic [NODE_W-1:0] n_eff;
  logic              q_valid, q_pop;
  qent_t             q_head;

  tlbl_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .n_eff(n_eff), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  tlbl_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .n_eff(n_eff),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule
